>>> rtl/hfnl_pkg.sv
package hfnl_pkg;

    localparam int MAX_ATOMS_DEFAULT     = 1024;
    localparam int MAX_NEIGHBORS_DEFAULT = 64;

    localparam int ATOMS_CFG_W = 11;
    localparam int LIMIT_CFG_W = 7;
    localparam int CFG_DATA_W  = 11;
    localparam int CNT_W       = 12;
    localparam int ATOM_I_W    = 10;
    localparam int ATOM_J_W    = 16;
    localparam int SLOT_W      = 6;

    localparam logic [CNT_W-1:0]       COUNT_CAP        = 12'd4095;
    localparam logic [ATOMS_CFG_W-1:0] ATOMS_RESET      = 11'd1024;
    localparam logic [LIMIT_CFG_W-1:0] LIMIT_RESET      = 7'd64;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        CFG_ATOMS_IN_USE   = 1'b0,
        CFG_NEIGHBOR_LIMIT = 1'b1
    } t_cfg_index;

endpackage

>>> rtl/hfnl_ram.sv
module hfnl_ram #(
    parameter int DEPTH = hfnl_pkg::MAX_ATOMS_DEFAULT,
    parameter int WIDTH = hfnl_pkg::CNT_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/half_to_full_neighbor_list_top.sv
// Full neighbor list builder. Each accepted item (clear, insert pair, read entry,
// unused mode) gives exactly one result. Counts live in a MAX_ATOMS deep memory
// and list entries in a MAX_ATOMS * MAX_NEIGHBORS deep memory, both with one
// write and one registered read port. A read, an unused mode or an insert with
// a ghost neighbor passes through the lookup and done states before the next
// transfer; an insert with a local neighbor adds a state for the second count's
// read-modify-write. A clear zeroes one count a cycle. After reset the block
// stalls its input while the same sweep zeroes the counts; configuration writes
// are taken throughout.
module half_to_full_neighbor_list_top #(
    parameter int MAX_ATOMS     = hfnl_pkg::MAX_ATOMS_DEFAULT,
    parameter int MAX_NEIGHBORS = hfnl_pkg::MAX_NEIGHBORS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_index,
    input  logic [hfnl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [1:0]                     i_mode,
    input  logic [hfnl_pkg::ATOM_I_W-1:0]  i_atom_i,
    input  logic [hfnl_pkg::ATOM_J_W-1:0]  i_atom_j,
    input  logic [hfnl_pkg::SLOT_W-1:0]    i_slot,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [hfnl_pkg::CNT_W-1:0]     o_count,
    output logic [hfnl_pkg::ATOM_J_W-1:0]  o_neighbor,
    output logic                           o_entry_valid,
    output logic                           o_overflow
);

    localparam int AW     = $clog2(MAX_ATOMS);
    localparam int NDEPTH = MAX_ATOMS * MAX_NEIGHBORS;
    localparam int NAW    = (NDEPTH > 1) ? $clog2(NDEPTH) : 1;
    localparam logic [16:0]   MaxAtomsW = 17'(MAX_ATOMS);
    localparam logic [10:0]   LimitMax  = 11'(MAX_NEIGHBORS);
    localparam logic [AW-1:0] LastAtom  = AW'(MAX_ATOMS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_CLEAR,
        S_INS_J,
        S_DONE
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_clr_idx;

    logic [hfnl_pkg::ATOMS_CFG_W-1:0] r_atoms_in_use;
    logic [hfnl_pkg::LIMIT_CFG_W-1:0] r_neighbor_limit;
    logic r_overflow;

    hfnl_pkg::t_mode r_mode;
    logic [hfnl_pkg::ATOM_I_W-1:0] r_atom_i;
    logic [hfnl_pkg::ATOM_J_W-1:0] r_atom_j;
    logic [hfnl_pkg::SLOT_W-1:0]   r_slot;
    logic [hfnl_pkg::CNT_W-1:0]    r_cnt_i;

    logic [hfnl_pkg::CNT_W-1:0]    r_res_count;
    logic [hfnl_pkg::ATOM_J_W-1:0] r_res_nb;
    logic                          r_res_ev;

    logic                          r_out_valid;
    logic [hfnl_pkg::CNT_W-1:0]    r_out_count;
    logic [hfnl_pkg::ATOM_J_W-1:0] r_out_nb;
    logic                          r_out_ev;
    logic                          r_out_ovf;

    logic                          cnt_we;
    logic [AW-1:0]                 cnt_waddr;
    logic [hfnl_pkg::CNT_W-1:0]    cnt_wdata;
    logic [AW-1:0]                 cnt_raddr;
    logic [hfnl_pkg::CNT_W-1:0]    cnt_q;
    logic                          nb_we;
    logic [NAW-1:0]                nb_waddr;
    logic [hfnl_pkg::ATOM_J_W-1:0] nb_wdata;
    logic [NAW-1:0]                nb_raddr;
    logic [hfnl_pkg::ATOM_J_W-1:0] nb_q;

    logic [16:0]                   eff_atoms;
    logic [10:0]                   eff_limit;
    logic                          owner_ok;
    logic                          j_local;
    logic                          same_atom;
    logic [hfnl_pkg::CNT_W-1:0]    old_i;
    logic [hfnl_pkg::CNT_W-1:0]    new_i;
    logic                          room_i;
    logic [hfnl_pkg::CNT_W-1:0]    old_j;
    logic [hfnl_pkg::CNT_W-1:0]    new_j;
    logic                          room_j;
    logic                          slot_ok;

    function automatic logic [NAW-1:0] nb_addr(input logic [15:0] owner,
                                               input logic [11:0] idx);
        return NAW'(32'(owner) * 32'(MAX_NEIGHBORS) + 32'(idx));
    endfunction

    hfnl_ram #(
        .DEPTH (MAX_ATOMS),
        .WIDTH (hfnl_pkg::CNT_W)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    hfnl_ram #(
        .DEPTH (NDEPTH),
        .WIDTH (hfnl_pkg::ATOM_J_W)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (nb_we),
        .i_waddr (nb_waddr),
        .i_wdata (nb_wdata),
        .i_raddr (nb_raddr),
        .o_rdata (nb_q)
    );

    assign eff_atoms = (17'(r_atoms_in_use) < MaxAtomsW) ? 17'(r_atoms_in_use) : MaxAtomsW;
    assign eff_limit = (11'(r_neighbor_limit) < LimitMax) ? 11'(r_neighbor_limit) : LimitMax;
    assign owner_ok  = 17'(r_atom_i) < MaxAtomsW;
    assign j_local   = 17'(r_atom_j) < eff_atoms;
    assign same_atom = r_atom_j == 16'(r_atom_i);

    assign old_i   = cnt_q;
    assign room_i  = old_i < 12'(eff_limit);
    assign new_i   = (old_i == hfnl_pkg::COUNT_CAP) ? old_i : old_i + 12'd1;

    // second append sees the first when both land on the same atom
    assign old_j   = same_atom ? r_cnt_i : cnt_q;
    assign room_j  = old_j < 12'(eff_limit);
    assign new_j   = (old_j == hfnl_pkg::COUNT_CAP) ? old_j : old_j + 12'd1;

    assign slot_ok = (12'(r_slot) < old_i) && (11'(r_slot) < eff_limit);

    assign cnt_raddr = (r_state == S_IDLE) ? AW'(i_atom_i) : AW'(r_atom_j);
    assign nb_raddr  = nb_addr(16'(i_atom_i), 12'(i_slot));

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_clr_idx;
        cnt_wdata = '0;
        nb_we     = 1'b0;
        nb_waddr  = nb_addr(16'(r_atom_i), old_i);
        nb_wdata  = r_atom_j;
        case (r_state)
            S_INIT, S_CLEAR: begin
                cnt_we = 1'b1;
            end
            S_LOOK: begin
                if (r_mode == hfnl_pkg::MODE_INSERT && owner_ok) begin
                    cnt_we    = 1'b1;
                    cnt_waddr = AW'(r_atom_i);
                    cnt_wdata = new_i;
                    nb_we     = room_i;
                end
            end
            S_INS_J: begin
                cnt_we    = 1'b1;
                cnt_waddr = AW'(r_atom_j);
                cnt_wdata = new_j;
                nb_we     = room_j;
                nb_waddr  = nb_addr(r_atom_j, old_j);
                nb_wdata  = 16'(r_atom_i);
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_INIT;
            r_clr_idx        <= '0;
            r_out_valid      <= 1'b0;
            r_overflow       <= 1'b0;
            r_atoms_in_use   <= hfnl_pkg::ATOMS_RESET;
            r_neighbor_limit <= hfnl_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                case (hfnl_pkg::t_cfg_index'(i_cfg_index))
                    hfnl_pkg::CFG_ATOMS_IN_USE: begin
                        r_atoms_in_use <= i_cfg_data;
                    end
                    hfnl_pkg::CFG_NEIGHBOR_LIMIT: begin
                        r_neighbor_limit <= i_cfg_data[hfnl_pkg::LIMIT_CFG_W-1:0];
                    end
                    default: begin
                        r_atoms_in_use <= r_atoms_in_use;
                    end
                endcase
            end

            // output register free or emptied by this transfer
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_INIT: begin
                    if (r_clr_idx == LastAtom) begin
                        r_clr_idx <= '0;
                        r_state   <= S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mode   <= hfnl_pkg::t_mode'(i_mode);
                        r_atom_i <= i_atom_i;
                        r_atom_j <= i_atom_j;
                        r_slot   <= i_slot;
                        r_state  <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    case (r_mode)
                        hfnl_pkg::MODE_CLEAR: begin
                            r_res_nb    <= '0;
                            r_res_ev    <= 1'b0;
                            r_res_count <= '0;
                            r_clr_idx   <= '0;
                            r_state     <= S_CLEAR;
                        end
                        hfnl_pkg::MODE_INSERT: begin
                            r_res_nb <= '0;
                            r_res_ev <= 1'b0;
                            if (owner_ok) begin
                                if (!room_i) begin
                                    r_overflow <= 1'b1;
                                end
                                r_cnt_i     <= new_i;
                                r_res_count <= new_i;
                                r_state     <= j_local ? S_INS_J : S_DONE;
                            end else begin
                                r_res_count <= '0;
                                r_state     <= S_DONE;
                            end
                        end
                        hfnl_pkg::MODE_READ: begin
                            r_res_count <= owner_ok ? old_i : '0;
                            r_res_ev    <= owner_ok && slot_ok;
                            r_res_nb    <= (owner_ok && slot_ok) ? nb_q : '0;
                            r_state     <= S_DONE;
                        end
                        default: begin
                            r_res_count <= owner_ok ? old_i : '0;
                            r_res_nb    <= '0;
                            r_res_ev    <= 1'b0;
                            r_state     <= S_DONE;
                        end
                    endcase
                end
                S_CLEAR: begin
                    if (r_clr_idx == LastAtom) begin
                        r_clr_idx <= '0;
                        r_state   <= S_DONE;
                    end else begin
                        r_clr_idx <= r_clr_idx + AW'(1);
                    end
                end
                S_INS_J: begin
                    if (!room_j) begin
                        r_overflow <= 1'b1;
                    end
                    if (same_atom) begin
                        r_res_count <= new_j;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_count <= r_res_count;
                        r_out_nb    <= r_res_nb;
                        r_out_ev    <= r_res_ev;
                        r_out_ovf   <= r_overflow;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = r_state != S_IDLE;
    assign o_out_valid   = r_out_valid;
    assign o_count       = r_out_count;
    assign o_neighbor    = r_out_nb;
    assign o_entry_valid = r_out_ev;
    assign o_overflow    = r_out_ovf;

endmodule
